[src/wpsd_pkg.sv]
package wpsd_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] left_sample;
    logic [15:0] right_sample;
    logic [2:0]  error_code;
    logic [15:0] output_rate;
    logic [31:0] output_length;
    logic [15:0] channel_count;
    logic [31:0] source_rate;
    logic [15:0] sample_bits;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CHUNK  = 3'd1,
    PH_FMT    = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DATA   = 3'd4,
    PH_HALT   = 3'd5
  } phase_e;

  // work handed from parser to emitter
  typedef enum logic [1:0] {
    JOB_NONE  = 2'd0,
    JOB_INFO  = 2'd1,
    JOB_FRAME = 2'd2
  } job_e;

  typedef enum logic [1:0] {
    KIND_INFO  = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SIGNATURE = 3'd1,
    ERR_NOT_PCM   = 3'd2,
    ERR_NO_FMT    = 3'd3,
    ERR_UNPLAY    = 3'd4,
    ERR_NO_DATA   = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    CV_IDLE = 2'd0,
    CV_DIV  = 2'd1
  } cv_state_e;

  // one parsed byte's outcome
  typedef struct packed {
    job_e        job;
    logic [15:0] left;
    logic [15:0] right;
    logic [2:0]  rep;        // frame copies 1,2 or 4
    logic [2:0]  err;        // trailing error, ERR_NONE if none
    logic [31:0] clen;       // data chunk length (info)
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
  } task_t;

  localparam logic [31:0] SIG_RIFF = 32'h46464952;
  localparam logic [31:0] SIG_WAVE = 32'h45564157;
  localparam logic [31:0] ID_FMT   = 32'h20746D66;
  localparam logic [31:0] ID_DATA  = 32'h61746164;
  localparam logic [15:0] TAG_PCM  = 16'h0001;
  localparam int unsigned QDEPTH   = 2;

endpackage

[src/wav_pcm_stream_decoder_top.sv]
// channel | dir | handshake      | payload
// input   | in  | push_i/full_o  | in_i  (in_item_t: file byte, end of file)
// result  | out | pop_i/empty_o  | out_o (out_item_t)
// One byte is parsed per cycle unless full_o stalls; a byte yields up to four results,
// one per cycle while popped and not empty. A data chunk header's format-info result
// waits for a bit-serial divider. The parser stalls (full_o) only when its task
// register and the two-entry task queue are full. Reset is asynchronous, active low.
module wav_pcm_stream_decoder_top
  import wpsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  in_item_t  in_i,
  output logic      full_o,
  output logic      empty_o,
  output out_item_t out_o,
  input  logic      pop_i
);

  logic  tvalid, tready;
  task_t tsk;

  // front: byte parsing
  wpsd_parse u_parse (
    .clk_i, .rst_ni, .push_i, .in_i, .full_o,
    .tvalid_o(tvalid), .task_o(tsk), .tready_i(tready)
  );

  // back: task queue, length divide, result sequencing
  wpsd_emit u_emit (
    .clk_i, .rst_ni, .tvalid_i(tvalid), .task_i(tsk), .tready_o(tready),
    .empty_o, .out_o, .pop_i
  );

endmodule

[src/wpsd_parse.sv]
module wpsd_parse
  import wpsd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t in_i,
  output logic     full_o,
  output logic     tvalid_o,
  output task_t    task_o,
  input  logic     tready_i
);

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] word_q, word_d;
  logic [31:0] clen_q, clen_d;
  logic [31:0] skip_q, skip_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [2:0]  rep_q, rep_d;
  logic [31:0] drem_q, drem_d;
  logic [31:0] fbytes_q, fbytes_d;
  logic [16:0] fcnt_q, fcnt_d;

  task_t       t;
  logic [7:0]  b;
  logic        eof;
  logic [31:0] take;
  logic [31:0] cwn, lenn;
  logic [3:0]  p;
  logic [31:0] fw;
  logic [2:0]  err;
  logic        fmt_ev, data_ev;
  logic        acc;

  // one byte per cycle, unless full_o stalls, into a one-entry task register
  assign full_o = tvalid_o && !tready_i;
  assign acc = push_i && !full_o;
  assign b   = in_i.file_byte;
  assign eof = in_i.end_of_file;

  function automatic logic [31:0] take_of(input logic [31:0] l);
    return (l < 32'd16) ? l : 32'd16;
  endfunction

  always_comb begin
    phase_d = phase_q; pos_d = pos_q; word_d = word_q; clen_d = clen_q;
    skip_d = skip_q; ch_d = ch_q; rate_d = rate_q; bits_d = bits_q;
    rep_d = rep_q; drem_d = drem_q; fbytes_d = fbytes_q; fcnt_d = fcnt_q;
    err = ERR_NONE; fmt_ev = 1'b0; data_ev = 1'b0;
    t = '0; t.job = JOB_NONE;
    cwn = {b, word_q[31:8]};
    lenn = {b, clen_q[31:8]};
    take = take_of(clen_q);
    p = pos_q[3:0];
    fw = word_q;
    unique case (phase_q)
      PH_HEADER: begin
        word_d = cwn;
        if (pos_q == 32'd3 && cwn != SIG_RIFF) err = ERR_SIGNATURE;
        else if (pos_q == 32'd11) begin
          if (cwn != SIG_WAVE) err = ERR_SIGNATURE;
          else begin
            phase_d = PH_CHUNK; pos_d = '0; word_d = '0;
          end
        end else pos_d = pos_q + 32'd1;
        if (eof && err == ERR_NONE && phase_d == PH_HEADER) err = ERR_SIGNATURE;
      end
      PH_CHUNK: begin
        if (pos_q < 32'd4) word_d = cwn; else clen_d = lenn;
        if (pos_q == 32'd3 && cwn == 32'd0) err = ERR_NO_DATA;
        else if (pos_q >= 32'd7) begin
          pos_d = '0;
          if (word_q == ID_FMT) begin
            word_d = '0; ch_d = '0; rate_d = '0; bits_d = '0;
            take = take_of(lenn);
            skip_d = lenn - take;
            if (take == 32'd0) fmt_ev = 1'b1; else phase_d = PH_FMT;
          end else if (word_q == ID_DATA) begin
            data_ev = 1'b1;
          end else begin
            skip_d = lenn;
            phase_d = (lenn != 0) ? PH_SKIP : PH_CHUNK;
          end
        end else pos_d = pos_q + 32'd1;
      end
      PH_FMT: begin
        if (p < 4'd2) word_d = word_q | ({24'd0, b} << {p, 3'd0});
        else if (p < 4'd4) ch_d = ch_q | ({8'd0, b} << {p - 4'd2, 3'd0});
        else if (p < 4'd8) rate_d = rate_q | ({24'd0, b} << {p - 4'd4, 3'd0});
        else if (p >= 4'd14) bits_d = bits_q | ({8'd0, b} << {p - 4'd14, 3'd0});
        pos_d = pos_q + 32'd1;
        if (pos_d >= take) fmt_ev = 1'b1;
      end
      PH_SKIP: begin
        skip_d = skip_q - 32'd1;
        if (skip_d == 0) begin phase_d = PH_CHUNK; pos_d = '0; end
      end
      PH_DATA: begin
        if (fcnt_q < 17'd4) fw = word_q | ({24'd0, b} << {fcnt_q[1:0], 3'd0});
        word_d = fw;
        fcnt_d = fcnt_q + 17'd1;
        drem_d = drem_q - 32'd1;
        if ({15'd0, fcnt_d} >= fbytes_q) begin
          t.job = (rep_q != 0) ? JOB_FRAME : JOB_NONE;
          t.rep = rep_q;
          if (bits_q == 16'd16) begin
            t.left = fw[15:0]; t.right = fw[31:16];
          end else begin
            t.left = {2'b0, fw[7:0], 6'b0}; t.right = {2'b0, fw[15:8], 6'b0};
          end
          if (ch_q == 16'd1) t.right = t.left;
          fcnt_d = '0; word_d = '0;
        end
        if (drem_d == 0) phase_d = PH_HALT;
      end
      default: ;
    endcase
    if (fmt_ev) begin
      if (word_d[15:0] != TAG_PCM) err = ERR_NOT_PCM;
      else begin
        if (rate_d == 32'd48000 || rate_d == 32'd44100) rep_d = 3'd1;
        else if (rate_d == 32'd24000 || rate_d == 32'd22050) rep_d = 3'd2;
        else if (rate_d == 32'd12000 || rate_d == 32'd11025) rep_d = 3'd4;
        else rep_d = 3'd0;
        pos_d = '0;
        phase_d = (skip_d != 0) ? PH_SKIP : PH_CHUNK;
      end
    end
    if (data_ev) begin
      if (ch_q == 0 || rate_q == 0 || bits_q == 0) err = ERR_NO_FMT;
      else if (rep_q == 0 || (bits_q != 16'd8 && bits_q != 16'd16)) err = ERR_UNPLAY;
      else begin
        t.job = JOB_INFO;
        t.clen = lenn; t.chans = ch_q; t.rate = rate_q; t.bits = bits_q;
        t.rep = rep_q;
        fbytes_d = {16'd0, ch_q} * {16'd0, 13'd0, bits_q[5:3]};
        drem_d = lenn; fcnt_d = '0; word_d = '0;
        phase_d = (lenn != 0) ? PH_DATA : PH_HALT;
      end
    end
    if (err != ERR_NONE) phase_d = PH_HALT;
    else if (eof && (phase_d == PH_CHUNK || phase_d == PH_FMT || phase_d == PH_SKIP))
      err = ERR_NO_DATA;
    t.err = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; pos_q <= '0; word_q <= '0; clen_q <= '0;
      skip_q <= '0; ch_q <= '0; rate_q <= '0; bits_q <= '0; rep_q <= '0;
      drem_q <= '0; fbytes_q <= '0; fcnt_q <= '0;
      tvalid_o <= 1'b0;
    end else begin
      if (acc) tvalid_o <= (t.job != JOB_NONE) || (t.err != ERR_NONE);
      else if (tready_i) tvalid_o <= 1'b0;
      if (acc) begin
        if (eof) begin
          phase_q <= PH_HEADER; pos_q <= '0; word_q <= '0; clen_q <= '0;
          skip_q <= '0; ch_q <= '0; rate_q <= '0; bits_q <= '0; rep_q <= '0;
          drem_q <= '0; fbytes_q <= '0; fcnt_q <= '0;
        end else begin
          phase_q <= phase_d; pos_q <= pos_d; word_q <= word_d; clen_q <= clen_d;
          skip_q <= skip_d; ch_q <= ch_d; rate_q <= rate_d; bits_q <= bits_d;
          rep_q <= rep_d; drem_q <= drem_d; fbytes_q <= fbytes_d; fcnt_q <= fcnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) task_o <= t;
  end

endmodule

[src/wpsd_emit.sv]
module wpsd_emit
  import wpsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      tvalid_i,
  input  task_t     task_i,
  output logic      tready_o,
  output logic      empty_o,
  output out_item_t out_o,
  input  logic      pop_i
);

  // small queue of parsed tasks
  task_t       q_mem [QDEPTH];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  task_t       cur;
  logic [2:0]  idx_q;      // results of the head task already sent
  logic [2:0]  nres;
  logic [2:0]  nfr;
  logic        is_err;
  logic [31:0] len_q;      // info length, computed over cycles
  logic [31:0] divq_q, divr_q;
  logic [5:0]  dstep_q;
  logic        len_ok_q;
  logic        dbusy_q;
  logic        take, sent;
  logic [32:0] trial;

  assign tready_o = (cnt_q != 2'd2);
  assign cur = q_mem[rp_q];
  assign nfr = (cur.job == JOB_FRAME) ? cur.rep : ((cur.job == JOB_INFO) ? 3'd1 : 3'd0);
  assign nres = nfr + ((cur.err != ERR_NONE) ? 3'd1 : 3'd0);
  assign is_err = (idx_q == nfr);
  assign empty_o = (cnt_q == 0) || ((cur.job == JOB_INFO) && !len_ok_q && !is_err);
  assign sent = pop_i && !empty_o;
  assign take = tvalid_i && tready_o;
  assign trial = {divr_q, divq_q[31]} - {17'd0, cur.chans};

  always_comb begin
    out_o = '0;
    if (is_err) begin
      out_o.result_kind = KIND_ERROR;
      out_o.error_code = cur.err;
    end else if (cur.job == JOB_INFO) begin
      out_o.result_kind = KIND_INFO;
      out_o.output_rate = 16'(cur.rate * {29'd0, cur.rep});
      out_o.output_length = len_q;
      out_o.channel_count = cur.chans;
      out_o.source_rate = cur.rate;
      out_o.sample_bits = cur.bits;
    end else begin
      out_o.result_kind = KIND_FRAME;
      out_o.left_sample = cur.left;
      out_o.right_sample = cur.right;
    end
    out_o.last_of_run = (idx_q + 3'd1 == nres);
  end

  always_ff @(posedge clk_i) begin
    if (take) q_mem[wp_q] <= tvalid_i ? task_i : task_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; idx_q <= '0;
      dbusy_q <= 1'b0; len_ok_q <= 1'b0; dstep_q <= '0;
    end else begin
      if (take) wp_q <= ~wp_q;
      cnt_q <= cnt_q + {1'b0, take} - {1'b0, sent && (idx_q + 3'd1 == nres)};
      if (sent) begin
        if (idx_q + 3'd1 == nres) begin
          idx_q <= '0; rp_q <= ~rp_q; len_ok_q <= 1'b0;
        end else idx_q <= idx_q + 3'd1;
      end
      // restoring divide of length by channels, one bit per cycle
      if (cnt_q != 0 && cur.job == JOB_INFO && !len_ok_q && !dbusy_q && !is_err) begin
        dbusy_q <= 1'b1; dstep_q <= 6'd32;
      end else if (dbusy_q) begin
        if (dstep_q == 6'd1) begin dbusy_q <= 1'b0; len_ok_q <= 1'b1; end
        dstep_q <= dstep_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!dbusy_q) begin
      divq_q <= cur.clen; divr_q <= '0;
    end else begin
      if (!trial[32]) begin
        divr_q <= trial[31:0]; divq_q <= {divq_q[30:0], 1'b1};
      end else begin
        divr_q <= {divr_q[30:0], divq_q[31]}; divq_q <= {divq_q[30:0], 1'b0};
      end
    end
    if (dbusy_q && dstep_q == 6'd1) begin
      len_q <= ((!trial[32] ? {divq_q[30:0], 1'b1} : {divq_q[30:0], 1'b0})
                << ((cur.bits == 16'd8) ? 2 : 1)) * {29'd0, cur.rep};
    end
  end

endmodule
